>>> rtl/core/vba_pkg.sv
package vba_pkg;

    localparam int COORD_WIDTH_DEF     = 11;
    localparam int ANGLE_FRAC_BITS_DEF = 6;
    localparam int CORDIC_STAGES_DEF   = 16;

    localparam int ZFRAC      = 20;
    localparam int Z_W        = 32;
    localparam int U_W        = 29;
    localparam int ATAN_LEN   = 24;

    localparam logic signed [Z_W-1:0] DEG_90  = Z_W'(90 * (2 ** ZFRAC));
    localparam logic signed [Z_W-1:0] DEG_180 = Z_W'(180 * (2 ** ZFRAC));
    localparam logic signed [Z_W-1:0] DEG_270 = Z_W'(270 * (2 ** ZFRAC));
    localparam logic signed [Z_W-1:0] DEG_360 = Z_W'(360 * (2 ** ZFRAC));

    localparam logic signed [Z_W-1:0] ATAN_DEG [ATAN_LEN] = '{
        32'sd47185920, 32'sd27855475, 32'sd14718068, 32'sd7471121,
        32'sd3750058,  32'sd1876857,  32'sd938658,   32'sd469357,
        32'sd234682,   32'sd117342,   32'sd58671,    32'sd29335,
        32'sd14668,    32'sd7334,     32'sd3667,     32'sd1833,
        32'sd917,      32'sd458,      32'sd229,      32'sd115,
        32'sd57,       32'sd29,       32'sd14,       32'sd7
    };

    typedef enum logic [2:0] {
        K_GEN,
        K_ZERO,
        K_POS_X,
        K_NEG_X,
        K_POS_Y,
        K_NEG_Y
    } t_vba_kind;

    typedef struct packed {
        logic      valid;
        t_vba_kind kind;
    } t_vba_tag;

endpackage

>>> rtl/core/vba_pre.sv
module vba_pre import vba_pkg::*; #(
    parameter int COORD_WIDTH   = COORD_WIDTH_DEF,
    parameter int CORDIC_STAGES = CORDIC_STAGES_DEF,
    parameter int XW            = COORD_WIDTH + CORDIC_STAGES + 3
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_en,
    input  logic                   i_valid,
    input  logic [COORD_WIDTH-1:0] i_x,
    input  logic [COORD_WIDTH-1:0] i_y,
    output t_vba_tag               o_tag,
    output logic signed [XW-1:0]   o_x,
    output logic signed [XW-1:0]   o_y,
    output logic signed [Z_W-1:0]  o_z
);

    logic signed [COORD_WIDTH:0] w_xe;
    logic signed [COORD_WIDTH:0] w_ye;
    logic signed [COORD_WIDTH:0] w_xs;
    logic signed [COORD_WIDTH:0] w_ys;
    logic signed [XW-1:0]        n_x;
    logic signed [XW-1:0]        n_y;
    logic signed [Z_W-1:0]       n_z;
    t_vba_kind                   n_kind;
    t_vba_tag                    r_tag;
    logic signed [XW-1:0]        r_x;
    logic signed [XW-1:0]        r_y;
    logic signed [Z_W-1:0]       r_z;

    always_comb begin
        w_xe = (COORD_WIDTH+1)'(signed'(i_x));
        w_ye = (COORD_WIDTH+1)'(signed'(i_y));
        if (w_xe < 0) begin
            w_xs = -w_xe;
            w_ys = -w_ye;
            n_z  = DEG_180;
        end else begin
            w_xs = w_xe;
            w_ys = w_ye;
            n_z  = '0;
        end
        n_x = XW'(w_xs) <<< CORDIC_STAGES;
        n_y = XW'(w_ys) <<< CORDIC_STAGES;
        if (w_xe == 0 && w_ye == 0) begin
            n_kind = K_ZERO;
        end else if (w_xe == 0) begin
            n_kind = (w_ye > 0) ? K_POS_Y : K_NEG_Y;
        end else if (w_ye == 0) begin
            n_kind = (w_xe > 0) ? K_POS_X : K_NEG_X;
        end else begin
            n_kind = K_GEN;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tag.valid <= 1'b0;
            r_tag.kind  <= K_GEN;
        end else if (i_en) begin
            r_tag.valid <= i_valid;
            r_tag.kind  <= n_kind;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_x <= n_x;
            r_y <= n_y;
            r_z <= n_z;
        end
    end

    assign o_tag = r_tag;
    assign o_x   = r_x;
    assign o_y   = r_y;
    assign o_z   = r_z;

endmodule

>>> rtl/core/vba_stage.sv
module vba_stage import vba_pkg::*; #(
    parameter int IDX = 0,
    parameter int XW  = 30
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_en,
    input  t_vba_tag              i_tag,
    input  logic signed [XW-1:0]  i_x,
    input  logic signed [XW-1:0]  i_y,
    input  logic signed [Z_W-1:0] i_z,
    output t_vba_tag              o_tag,
    output logic signed [XW-1:0]  o_x,
    output logic signed [XW-1:0]  o_y,
    output logic signed [Z_W-1:0] o_z
);

    localparam logic signed [Z_W-1:0] STEP = ATAN_DEG[IDX];

    logic signed [XW-1:0]  w_dx;
    logic signed [XW-1:0]  w_dy;
    logic signed [XW-1:0]  n_x;
    logic signed [XW-1:0]  n_y;
    logic signed [Z_W-1:0] n_z;
    t_vba_tag              r_tag;
    logic signed [XW-1:0]  r_x;
    logic signed [XW-1:0]  r_y;
    logic signed [Z_W-1:0] r_z;

    always_comb begin
        w_dx = i_y >>> IDX;
        w_dy = i_x >>> IDX;
        if (i_y > 0) begin
            n_x = i_x + w_dx;
            n_y = i_y - w_dy;
            n_z = i_z + STEP;
        end else begin
            n_x = i_x - w_dx;
            n_y = i_y + w_dy;
            n_z = i_z - STEP;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tag.valid <= 1'b0;
            r_tag.kind  <= K_GEN;
        end else if (i_en) begin
            r_tag <= i_tag;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_x <= n_x;
            r_y <= n_y;
            r_z <= n_z;
        end
    end

    assign o_tag = r_tag;
    assign o_x   = r_x;
    assign o_y   = r_y;
    assign o_z   = r_z;

endmodule

>>> rtl/core/vba_post.sv
module vba_post import vba_pkg::*; #(
    parameter int ANGLE_FRAC_BITS = ANGLE_FRAC_BITS_DEF,
    parameter int BW              = ANGLE_FRAC_BITS + 9
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_en,
    input  t_vba_tag              i_tag,
    input  logic signed [Z_W-1:0] i_z,
    output logic                  o_valid,
    output logic [BW-1:0]         o_bearing,
    output logic                  o_zero
);

    localparam int SH = ZFRAC - ANGLE_FRAC_BITS;
    localparam int RW = BW + 1;
    localparam logic [U_W:0]    HALF_LSB  = (U_W+1)'(2 ** (SH - 1));
    localparam logic [RW-1:0]   FULL      = RW'(360 * (2 ** ANGLE_FRAC_BITS));
    localparam logic [RW-1:0]   HALF_TURN = RW'(180 * (2 ** ANGLE_FRAC_BITS));

    logic signed [Z_W-1:0] w_u;
    logic [U_W-1:0]        n_u;
    logic [U_W:0]          w_sum;
    logic [RW-1:0]         w_r;
    logic [RW-1:0]         w_r1;
    logic [BW-1:0]         n_bearing;
    logic                  r_mid_valid;
    logic                  r_mid_zero;
    logic [U_W-1:0]        r_u;
    logic                  r_valid;
    logic                  r_zero;
    logic [BW-1:0]         r_bearing;

    always_comb begin
        w_u = i_z - DEG_90;
        n_u = '0;
        case (i_tag.kind)
            K_GEN:   n_u = (w_u < 0) ? U_W'(w_u + DEG_360) : U_W'(w_u);
            K_ZERO:  n_u = '0;
            K_POS_X: n_u = U_W'(DEG_270);
            K_NEG_X: n_u = U_W'(DEG_90);
            K_POS_Y: n_u = '0;
            K_NEG_Y: n_u = U_W'(DEG_180);
            default: n_u = '0;
        endcase
    end

    always_comb begin
        w_sum = {1'b0, r_u} + HALF_LSB;
        w_r   = RW'(w_sum >> SH);
        w_r1  = (w_r >= FULL) ? (w_r - FULL) : w_r;
        if (r_mid_zero) begin
            n_bearing = '0;
        end else if (w_r1 > HALF_TURN) begin
            n_bearing = BW'(w_r1 - FULL);
        end else begin
            n_bearing = BW'(w_r1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mid_valid <= 1'b0;
            r_valid     <= 1'b0;
        end else if (i_en) begin
            r_mid_valid <= i_tag.valid;
            r_valid     <= r_mid_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_u        <= n_u;
            r_mid_zero <= (i_tag.kind == K_ZERO);
            r_zero     <= r_mid_zero;
            r_bearing  <= n_bearing;
        end
    end

    assign o_valid   = r_valid;
    assign o_bearing = r_bearing;
    assign o_zero    = r_zero;

endmodule

>>> rtl/core/vector_bearing_angle.sv
// Channel | Dir | Handshake               | Payload
// s       | in  | i_s_tvalid / o_s_tready | i_s_tdata: offset_x, offset_y
// m       | out | o_m_tvalid / i_m_tready | o_m_tdata: bearing; o_m_tuser: zero_vector
//
// One offset pair accepted per cycle while the m side is not stalled; the pipeline
// registers are prerotate, one register per micro-rotation, wrap, round/output.
// The micro-rotation chain is unrolled, one rotation per stage.
// i_rst_n clears all valid bits synchronously; data registers are not reset.
// A stall on the m side freezes the whole pipeline; nothing is dropped or repeated.
module vector_bearing_angle import vba_pkg::*; #(
    parameter int COORD_WIDTH     = COORD_WIDTH_DEF,
    parameter int ANGLE_FRAC_BITS = ANGLE_FRAC_BITS_DEF,
    parameter int CORDIC_STAGES   = CORDIC_STAGES_DEF,
    parameter int DIN_W           = ((2 * COORD_WIDTH + 7) / 8) * 8,
    parameter int BW              = ANGLE_FRAC_BITS + 9,
    parameter int DOUT_W          = ((BW + 7) / 8) * 8
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_s_tvalid,
    output logic              o_s_tready,
    input  logic [DIN_W-1:0]  i_s_tdata,   // offset_x, offset_y, zero pad
    output logic              o_m_tvalid,
    input  logic              i_m_tready,
    output logic [DOUT_W-1:0] o_m_tdata,   // bearing, zero pad
    output logic              o_m_tuser    // zero_vector
);

    localparam int XW = COORD_WIDTH + CORDIC_STAGES + 3;

    logic                  w_en;
    t_vba_tag              w_tag [CORDIC_STAGES+1];
    logic signed [XW-1:0]  w_x   [CORDIC_STAGES+1];
    logic signed [XW-1:0]  w_y   [CORDIC_STAGES+1];
    logic signed [Z_W-1:0] w_z   [CORDIC_STAGES+1];
    logic                  w_valid;
    logic [BW-1:0]         w_bearing;
    logic                  w_zero;

    // advance unless the output holds an untaken transfer
    assign w_en       = !w_valid || i_m_tready;
    assign o_s_tready = w_en;

    vba_pre #(
        .COORD_WIDTH  (COORD_WIDTH),
        .CORDIC_STAGES(CORDIC_STAGES),
        .XW           (XW)
    ) u_pre (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_en   (w_en),
        .i_valid(i_s_tvalid),
        .i_x    (i_s_tdata[COORD_WIDTH-1:0]),
        .i_y    (i_s_tdata[2*COORD_WIDTH-1:COORD_WIDTH]),
        .o_tag  (w_tag[0]),
        .o_x    (w_x[0]),
        .o_y    (w_y[0]),
        .o_z    (w_z[0])
    );

    for (genvar g = 0; g < CORDIC_STAGES; g++) begin : g_rot
        vba_stage #(
            .IDX(g),
            .XW (XW)
        ) u_stage (
            .i_clk  (i_clk),
            .i_rst_n(i_rst_n),
            .i_en   (w_en),
            .i_tag  (w_tag[g]),
            .i_x    (w_x[g]),
            .i_y    (w_y[g]),
            .i_z    (w_z[g]),
            .o_tag  (w_tag[g+1]),
            .o_x    (w_x[g+1]),
            .o_y    (w_y[g+1]),
            .o_z    (w_z[g+1])
        );
    end

    vba_post #(
        .ANGLE_FRAC_BITS(ANGLE_FRAC_BITS),
        .BW             (BW)
    ) u_post (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_en     (w_en),
        .i_tag    (w_tag[CORDIC_STAGES]),
        .i_z      (w_z[CORDIC_STAGES]),
        .o_valid  (w_valid),
        .o_bearing(w_bearing),
        .o_zero   (w_zero)
    );

    assign o_m_tvalid = w_valid;
    assign o_m_tdata  = DOUT_W'(w_bearing);
    assign o_m_tuser  = w_zero;

    a_zero_bearing: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && o_m_tuser) |-> (w_bearing == '0))
        else $error("zero vector with nonzero bearing");

    a_bearing_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> ($signed(w_bearing) > -$signed(BW'(180 * (2 ** ANGLE_FRAC_BITS))))
                    && ($signed(w_bearing) <= $signed(BW'(180 * (2 ** ANGLE_FRAC_BITS)))))
        else $error("bearing outside half turn");

    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && !i_m_tready) |=> (o_m_tvalid && $stable(w_bearing)))
        else $error("stalled result changed");

    a_input_blocked: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && !i_m_tready) |-> !o_s_tready)
        else $error("input taken while pipeline frozen");

endmodule

>>> tb/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
    import vba_pkg::*;

    localparam int CW        = COORD_WIDTH_DEF;
    localparam int AFRAC     = ANGLE_FRAC_BITS_DEF;
    localparam int STAGES    = CORDIC_STAGES_DEF;
    localparam int DIN_W     = ((2 * CW + 7) / 8) * 8;
    localparam int BW        = AFRAC + 9;
    localparam int DOUT_W    = ((BW + 7) / 8) * 8;
    localparam int LATENCY   = STAGES + 3;
    localparam int WDOG_MAX  = 4000;
    localparam int HOLD_LEN  = 400;

    localparam longint DEG_ONE    = 64'sd1 <<< 20;
    localparam longint FULL_TURN  = 64'sd360 <<< AFRAC;
    localparam longint HALF_TURN  = 64'sd180 <<< AFRAC;
    localparam int     ROUND_SH   = 20 - AFRAC;

    localparam longint ARCTAN_DEG [24] = '{
        47185920, 27855475, 14718068, 7471121, 3750058, 1876857, 938658, 469357,
        234682, 117342, 58671, 29335, 14668, 7334, 3667, 1833,
        917, 458, 229, 115, 57, 29, 14, 7
    };

    typedef struct {
        logic [BW-1:0] bearing;
        logic          zero_vector;
    } t_bearing;

    logic              i_clk;
    logic              i_rst_n    = 1'b0;
    logic              i_s_tvalid = 1'b0;
    logic              o_s_tready;
    logic [DIN_W-1:0]  i_s_tdata  = '0;   // offset_x, offset_y, zero pad
    logic              o_m_tvalid;
    logic              i_m_tready = 1'b1;
    logic [DOUT_W-1:0] o_m_tdata;         // bearing, zero pad
    logic              o_m_tuser;         // zero_vector

    t_bearing expected_bearings [$];
    int       error_count  = 0;
    int       quiet_cycles = 0;
    bit       tx_idle      = 1'b1;
    bit       rx_idle      = 1'b1;
    int       hold_count   = 0;

    vector_bearing_angle dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tuser  (o_m_tuser)
    );

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    function automatic t_bearing predict_bearing(input logic signed [CW-1:0] ox,
                                                 input logic signed [CW-1:0] oy);
        t_bearing res;
        longint   x, y, xs, ys, dx, dy, a, u, r;
        x = longint'(ox);
        y = longint'(oy);
        res.zero_vector = 1'b0;
        if (x == 0 && y == 0) begin
            res.bearing     = '0;
            res.zero_vector = 1'b1;
            return res;
        end
        if (x == 0) begin
            a = (y > 0) ? 90 * DEG_ONE : -90 * DEG_ONE;
        end else if (y == 0) begin
            a = (x > 0) ? 0 : 180 * DEG_ONE;
        end else begin
            a = 0;
            if (x < 0) begin
                x = -x;
                y = -y;
                a = 180 * DEG_ONE;
            end
            xs = x * (64'sd1 <<< STAGES);
            ys = y * (64'sd1 <<< STAGES);
            for (int i = 0; i < STAGES && i < 24; i++) begin
                dx = ys >>> i;
                dy = xs >>> i;
                if (ys > 0) begin
                    xs += dx;
                    ys -= dy;
                    a  += ARCTAN_DEG[i];
                end else begin
                    xs -= dx;
                    ys += dy;
                    a  -= ARCTAN_DEG[i];
                end
            end
        end
        u = a - 90 * DEG_ONE;
        while (u < 0) u += 360 * DEG_ONE;
        while (u >= 360 * DEG_ONE) u -= 360 * DEG_ONE;
        r = (u + (64'sd1 <<< (ROUND_SH - 1))) >>> ROUND_SH;
        if (r >= FULL_TURN) r -= FULL_TURN;
        if (r > HALF_TURN) r -= FULL_TURN;
        res.bearing = r[BW-1:0];
        return res;
    endfunction

    // call right after a rising edge; returns at the edge of the transfer
    task automatic send_offset(input logic signed [CW-1:0] ox,
                               input logic signed [CW-1:0] oy);
        int gap;
        gap = tx_idle ? $urandom_range(0, 11) : 0;
        if (gap > 0) begin
            i_s_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= {{(DIN_W - 2 * CW){1'b0}}, oy, ox};
        @(posedge i_clk);
        while (!o_s_tready) @(posedge i_clk);
        expected_bearings = {expected_bearings, predict_bearing(ox, oy)};
    endtask

    task automatic send_random_offset();
        logic signed [CW-1:0] ox, oy;
        int                   sx, sy;
        case ($urandom_range(0, 11))
            0: begin
                ox = '0;
                oy = CW'($urandom());
            end
            1: begin
                ox = CW'($urandom());
                oy = '0;
            end
            2: begin
                ox = '0;
                oy = '0;
            end
            3, 4: begin
                sx = int'($urandom_range(0, 16)) - 8;
                sy = int'($urandom_range(0, 16)) - 8;
                ox = sx[CW-1:0];
                oy = sy[CW-1:0];
            end
            default: begin
                ox = CW'($urandom());
                oy = CW'($urandom());
            end
        endcase
        send_offset(ox, oy);
    endtask

    task automatic test_axes_and_corners();
        tx_idle = 1'b1;
        rx_idle = 1'b1;
        send_offset('0, '0);
        send_offset(CW'(1), '0);
        send_offset(CW'(-1), '0);
        send_offset('0, CW'(1));
        send_offset('0, CW'(-1));
        send_offset(CW'(1023), '0);
        send_offset(CW'(-1024), '0);
        send_offset('0, CW'(1023));
        send_offset('0, CW'(-1024));
        send_offset(CW'(1023), CW'(1023));
        send_offset(CW'(-1024), CW'(-1024));
        send_offset(CW'(-1024), CW'(1023));
        send_offset(CW'(1023), CW'(-1024));
        send_offset(CW'(1), CW'(1));
        send_offset(CW'(-1), CW'(-1));
        send_offset(CW'(1), CW'(-1));
        send_offset(CW'(-1), CW'(1));
        send_offset(CW'(1023), CW'(1));
        send_offset(CW'(1023), CW'(-1));
        send_offset(CW'(-1024), CW'(1));
        send_offset(CW'(-1024), CW'(-1));
        send_offset(CW'(1), CW'(-1024));
        send_offset(CW'(-1), CW'(-1024));
    endtask

    task automatic test_random_idling(input int count);
        tx_idle = 1'b1;
        rx_idle = 1'b1;
        repeat (count) send_random_offset();
    endtask

    task automatic test_full_rate(input int count);
        tx_idle = 1'b0;
        rx_idle = 1'b0;
        repeat (count) send_random_offset();
    endtask

    task automatic test_output_hold(input int count);
        tx_idle = 1'b0;
        rx_idle = 1'b0;
        hold_count++;
        repeat (count) send_random_offset();
        rx_idle = 1'b1;
    endtask

    task automatic test_mixed_idling(input int count);
        repeat (count) begin
            tx_idle = 1'($urandom_range(0, 1));
            rx_idle = 1'($urandom_range(0, 1));
            send_random_offset();
        end
    endtask

    // receiver: stall after transfers, and one long hold on request
    initial begin : sink
        int stall_left;
        int hold_left;
        int hold_seen;
        stall_left = 0;
        hold_left  = 0;
        hold_seen  = 0;
        forever begin
            @(posedge i_clk);
            if (hold_count != hold_seen) begin
                hold_left = HOLD_LEN;
                hold_seen = hold_count;
            end
            if (o_m_tvalid && i_m_tready && rx_idle)
                stall_left = $urandom_range(0, 11);
            if (hold_left > 0) begin
                hold_left--;
                i_m_tready <= 1'b0;
            end else if (stall_left > 0) begin
                stall_left--;
                i_m_tready <= 1'b0;
            end else begin
                i_m_tready <= 1'b1;
            end
        end
    end

    always @(posedge i_clk) begin
        t_bearing want;
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            if (expected_bearings.size() == 0) begin
                $error("unexpected transfer: bearing %0d zero_vector %0b",
                       $signed(o_m_tdata[BW-1:0]), o_m_tuser);
                error_count++;
            end else begin
                want = expected_bearings.pop_front();
                if (o_m_tdata[BW-1:0] !== want.bearing) begin
                    $error("bearing: expected %0d, actual %0d",
                           $signed(want.bearing), $signed(o_m_tdata[BW-1:0]));
                    error_count++;
                end
                if (o_m_tuser !== want.zero_vector) begin
                    $error("zero_vector: expected %0b, actual %0b",
                           want.zero_vector, o_m_tuser);
                    error_count++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (i_s_tvalid && o_s_tready) || (o_m_tvalid && i_m_tready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WDOG_MAX) begin
            $display("tb_top: done, errors");
            $finish;
        end
    end

    initial begin
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_axes_and_corners();
        test_random_idling(450);
        test_full_rate(200);
        test_output_hold(100);
        test_mixed_idling(380);
        i_s_tvalid <= 1'b0;
        while (expected_bearings.size() != 0) @(posedge i_clk);
        repeat (LATENCY + 10) @(posedge i_clk);
        if (error_count == 0)
            $display("tb_top: done, clean");
        else
            $display("tb_top: done, errors");
        $finish;
    end

endmodule

>>> sim.f
rtl/core/vba_pkg.sv
rtl/core/vba_pre.sv
rtl/core/vba_stage.sv
rtl/core/vba_post.sv
rtl/core/vector_bearing_angle.sv
tb/tb_top.sv
